FILE: rtl/core/depq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depq_pkg
// Shared types and constants for the double-ended priority queue core.
// ----------------------------------------------------------------------------
package depq_pkg;

   localparam int CAPACITY_DEFAULT = 256;
   localparam int VALUE_WIDTH      = 32;
   localparam int COUNT_OUT_WIDTH  = 9;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_DEL_MIN = 2'd1;
   localparam logic [1:0] OP_DEL_MAX = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_EMPTY   = 2'd2;

   // per-step command from sequencer to the store datapath
   typedef struct packed {
      logic rd_en;    // read entry at rd_addr
      logic wr_en;    // write entry at wr_addr
      logic wr_key;   // write data is the new key, else the read data
   } store_ctl_type;

endpackage

FILE: rtl/core/double_ended_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_priority_queue_core
// Bounded multiset of signed values with insert, delete-min, delete-max, clear.
// ----------------------------------------------------------------------------
// Values sit in ascending order in one single-port-per-direction memory and a
// small sequencer walks it with a shared comparator. busy is high from the
// edge that accepts start until the result beat, which is the first cycle
// with busy low again. Clear, delete-max and any dropped or ignored operation
// go straight to reading the minimum and maximum. Insert shifts each larger
// entry up one place from the top and then writes the key into the gap;
// delete-min shifts each entry above the first down one place. Every
// operation ends by reading the minimum at address 0 and the maximum at
// the top. A new start is taken only in idle, so the core finishes one
// operation before it accepts the next. rsp_valid marks the result for that
// one cycle and the receiver must take it. No clearing pass is needed after
// reset.
module double_ended_priority_queue_core #(
   parameter int CAPACITY = depq_pkg::CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_max_value,
   output logic signed [31:0] rsp_min_value,
   output logic               rsp_is_empty,
   output logic [8:0]         rsp_stored_count,
   output logic [1:0]         rsp_status
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SHIFT = 3'd1; // read issued, wait data
   localparam logic [2:0] ST_STEP  = 3'd2; // data in, compare and move
   localparam logic [2:0] ST_MIN   = 3'd3; // fetch min
   localparam logic [2:0] ST_MAX   = 3'd4; // fetch max
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [31:0]   key_ff, key_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW:0]   pos_ff, pos_in;
   logic [1:0]    status_ff, status_in;
   logic [31:0]   min_ff, min_in, max_ff, max_in;
   logic          valid_ff, valid_in;

   depq_pkg::store_ctl_type ctl;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [31:0]   rd_data;
   logic          rd_gt_key;

   depq_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
      .clock    (clock),
      .ctl      (ctl),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .key      (key_ff),
      .rd_data  (rd_data),
      .rd_gt_key(rd_gt_key)
   );

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      status_in = status_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      valid_in  = 1'b0;
      ctl       = '0;
      rd_addr   = '0;
      wr_addr   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in     = req_op;
               key_in    = req_value ^ 32'h8000_0000;
               status_in = depq_pkg::STATUS_DONE;
               state_in  = ST_MIN;
               case (req_op)
                  depq_pkg::OP_INSERT: begin
                     if (CW'(CAPACITY) == count_ff) begin
                        status_in = depq_pkg::STATUS_FULL;
                     end else if (count_ff != '0) begin
                        pos_in   = (AW+1)'(count_ff);
                        state_in = ST_SHIFT;
                     end else begin
                        pos_in   = '0;
                        state_in = ST_STEP;
                     end
                  end
                  depq_pkg::OP_DEL_MIN: begin
                     if (count_ff == '0) begin
                        status_in = depq_pkg::STATUS_EMPTY;
                     end else begin
                        pos_in   = (AW+1)'(1);
                        state_in = ST_SHIFT;
                     end
                  end
                  depq_pkg::OP_DEL_MAX: begin
                     if (count_ff == '0) begin
                        status_in = depq_pkg::STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  default: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            // insert reads pos-1, delete-min reads pos
            ctl.rd_en = 1'b1;
            if (op_ff == depq_pkg::OP_INSERT) begin
               rd_addr = AW'(pos_ff - 1'b1);
            end else begin
               rd_addr = AW'(pos_ff);
            end
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (op_ff == depq_pkg::OP_INSERT) begin
               if (pos_ff != '0 && rd_gt_key) begin
                  ctl.wr_en = 1'b1;
                  wr_addr   = AW'(pos_ff);
                  pos_in    = pos_ff - 1'b1;
                  state_in  = (pos_ff == (AW+1)'(1)) ? ST_STEP : ST_SHIFT;
                  if (pos_ff == (AW+1)'(1)) begin
                     // nothing below; next pass writes key at 0
                     state_in = ST_MIN;
                     ctl.wr_key = 1'b0;
                  end
               end else begin
                  ctl.wr_en  = 1'b1;
                  ctl.wr_key = 1'b1;
                  wr_addr    = AW'(pos_ff);
                  count_in   = count_ff + 1'b1;
                  state_in   = ST_MIN;
               end
               if (pos_ff == (AW+1)'(1) && rd_gt_key) begin
                  state_in = ST_STEP;
                  pos_in   = '0;
               end
            end else begin
               ctl.wr_en = 1'b1;
               wr_addr   = AW'(pos_ff - 1'b1);
               if ((CW)'(pos_ff + 1'b1) < count_ff) begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = ST_SHIFT;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = ST_MIN;
               end
            end
         end
         ST_MIN: begin
            ctl.rd_en = 1'b1;
            rd_addr   = '0;
            state_in  = ST_MAX;
         end
         ST_MAX: begin
            min_in    = rd_data ^ 32'h8000_0000;
            ctl.rd_en = 1'b1;
            rd_addr   = AW'(count_ff - 1'b1);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            max_in   = rd_data ^ 32'h8000_0000;
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      min_ff    <= min_in;
      max_ff    <= max_in;
   end

   assign busy             = state_ff != ST_IDLE;
   assign rsp_valid        = valid_ff;
   assign rsp_is_empty     = count_ff == '0;
   assign rsp_max_value    = rsp_is_empty ? '0 : max_ff;
   assign rsp_min_value    = rsp_is_empty ? '0 : min_ff;
   assign rsp_stored_count = 9'(count_ff);
   assign rsp_status       = status_ff;

endmodule

FILE: rtl/core/depq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depq_store
// Ordered value memory with one registered read port, one write port and a
// shared key comparator.
// ----------------------------------------------------------------------------
module depq_store #(
   parameter int CAPACITY = depq_pkg::CAPACITY_DEFAULT,
   parameter int AW       = $clog2(CAPACITY)
) (
   input  logic                   clock,
   input  depq_pkg::store_ctl_type ctl,
   input  logic [AW-1:0]          rd_addr,
   input  logic [AW-1:0]          wr_addr,
   input  logic [31:0]            key,
   output logic [31:0]            rd_data,
   output logic                   rd_gt_key
);

   logic [31:0] mem [CAPACITY];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= ctl.wr_key ? key : rd_data_ff;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data   = rd_data_ff;
   // biased keys, so unsigned compare gives signed order
   assign rd_gt_key = rd_data_ff > key;

endmodule

FILE: rtl/core/depq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depq_checker
// Port-level checks for the double-ended priority queue core.
// ----------------------------------------------------------------------------
module depq_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_max_value,
   input logic signed [31:0] rsp_min_value,
   input logic               rsp_is_empty,
   input logic [8:0]         rsp_stored_count,
   input logic [1:0]         rsp_status
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted beat did not raise busy");

   a_valid_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result beat while still busy");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_stored_count == 9'd0 &&
      rsp_max_value == 32'sd0 && rsp_min_value == 32'sd0)
      else $error("empty result not zeroed");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_empty |-> rsp_min_value <= rsp_max_value)
      else $error("minimum above maximum");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == depq_pkg::STATUS_EMPTY |-> rsp_is_empty)
      else $error("empty status with values stored");

endmodule

bind double_ended_priority_queue_core depq_checker u_depq_checker (.*);
